/* rtl/core/qgi_pkg.sv */
// ----------------------------------------------------------------------------
// qgi_pkg
// Shared types, constants and tables of the quaternion gyro integrator.
// ----------------------------------------------------------------------------
package qgi_pkg;

  localparam int RATE_W = 24;
  localparam int TS_W   = 24;
  localparam int MIN_W  = 16;
  localparam int QW     = 32;
  localparam int WM_W   = 38;
  localparam int ACC_W  = 66;
  localparam int MAG_W  = 65;
  localparam int ZR_W   = 39;
  localparam int CW     = 34;
  localparam int IDX_W  = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_QUAT_FRAC_BITS    = 30;
  localparam int DEF_CORDIC_ITERATIONS = 24;

  localparam logic [32:0] ANG_PI      = 33'd3373259426;
  localparam logic [32:0] ANG_TWO_PI  = 33'd6746518852;
  localparam logic [32:0] ANG_HALF_PI = 33'd1686629713;
  localparam logic [32:0] CORDIC_GAIN = 33'd652032874;

  localparam logic [TS_W-1:0]  TS_RESET  = 24'd41943;
  localparam logic [MIN_W-1:0] MIN_RESET = 16'd1;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 8'd1;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_ACCEPT   = 5'd1;
  localparam op_t OP_WMUL     = 5'd2;
  localparam op_t OP_WROUND   = 5'd3;
  localparam op_t OP_WSHIFT   = 5'd4;
  localparam op_t OP_SQMUL_W  = 5'd5;
  localparam op_t OP_SQMUL_M  = 5'd6;
  localparam op_t OP_SUMACC   = 5'd7;
  localparam op_t OP_SQRT_INI = 5'd8;
  localparam op_t OP_SQRT_STP = 5'd9;
  localparam op_t OP_HALF     = 5'd10;
  localparam op_t OP_MOD      = 5'd11;
  localparam op_t OP_FOLD     = 5'd12;
  localparam op_t OP_CORDIC   = 5'd13;
  localparam op_t OP_SINC     = 5'd14;
  localparam op_t OP_RMUL     = 5'd15;
  localparam op_t OP_RDLOAD   = 5'd16;
  localparam op_t OP_QDLOAD   = 5'd17;
  localparam op_t OP_DIV_STP  = 5'd18;
  localparam op_t OP_RSTORE   = 5'd19;
  localparam op_t OP_QSTORE   = 5'd20;
  localparam op_t OP_HMUL     = 5'd21;
  localparam op_t OP_HACC     = 5'd22;
  localparam op_t OP_MMAG     = 5'd23;
  localparam op_t OP_MSHIFT   = 5'd24;
  localparam op_t OP_EMIT     = 5'd25;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             flag;
  } dp_cmd_t;

  typedef struct packed {
    logic wbig;
    logic mbig;
    logic below_min;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0] qa;
    logic [1:0] rb;
    logic       neg;
  } ham_term_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd31: v = 30'd0;
      default: v = 30'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  // hamilton product q x r, term t feeds part t/4
  function automatic ham_term_t ham_term(input logic [3:0] t);
    ham_term_t h;
    case (t)
      4'd0:  h = '{qa: 2'd0, rb: 2'd0, neg: 1'b0};
      4'd1:  h = '{qa: 2'd1, rb: 2'd1, neg: 1'b1};
      4'd2:  h = '{qa: 2'd2, rb: 2'd2, neg: 1'b1};
      4'd3:  h = '{qa: 2'd3, rb: 2'd3, neg: 1'b1};
      4'd4:  h = '{qa: 2'd0, rb: 2'd1, neg: 1'b0};
      4'd5:  h = '{qa: 2'd1, rb: 2'd0, neg: 1'b0};
      4'd6:  h = '{qa: 2'd2, rb: 2'd3, neg: 1'b0};
      4'd7:  h = '{qa: 2'd3, rb: 2'd2, neg: 1'b1};
      4'd8:  h = '{qa: 2'd0, rb: 2'd2, neg: 1'b0};
      4'd9:  h = '{qa: 2'd1, rb: 2'd3, neg: 1'b1};
      4'd10: h = '{qa: 2'd2, rb: 2'd0, neg: 1'b0};
      4'd11: h = '{qa: 2'd3, rb: 2'd1, neg: 1'b0};
      4'd12: h = '{qa: 2'd0, rb: 2'd3, neg: 1'b0};
      4'd13: h = '{qa: 2'd1, rb: 2'd2, neg: 1'b0};
      4'd14: h = '{qa: 2'd2, rb: 2'd1, neg: 1'b1};
      default: h = '{qa: 2'd3, rb: 2'd0, neg: 1'b0};
    endcase
    return h;
  endfunction

endpackage

/* rtl/core/qgi_datapath.sv */
// ----------------------------------------------------------------------------
// qgi_datapath
// Registers and arithmetic: shared multiplier, square root, divider, cordic.
// ----------------------------------------------------------------------------
module qgi_datapath
  import qgi_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = DEF_QUAT_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  kind,
  input  logic [RATE_W-1:0]     rate [3],
  input  logic [QW-1:0]         load [4],
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [QW-1:0]         quat [4],
  output logic                  unchanged
);

  logic [TS_W-1:0]  ts_r;
  logic [MIN_W-1:0] min_r;
  logic [QW-1:0]    q_r [4];
  logic [RATE_W-1:0] rmag_r [3];
  logic             rneg_r [3];
  logic [63:0]      prod_r;
  logic [WM_W-1:0]  wm_r [3];
  logic [2:0]       sh_r;
  logic [63:0]      sum_r;
  logic [63:0]      rad_r;
  logic [33:0]      rem_r;
  logic [31:0]      root_r;
  logic [ZR_W-1:0]  zred_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic             negc_r;
  logic [QW-1:0]    r_r [4];
  logic [31:0]      sm_r;
  logic             sneg_r;
  logic [31:0]      dlo_r, drem_r, dden_r;
  logic signed [ACC_W-1:0] acc_r [4];
  logic             hneg_r;
  logic [MAG_W-1:0] m_r [4];
  logic             pneg_r [4];
  logic [QW-1:0]    out_q_r [4];
  logic             out_unch_r;

  logic [1:0]       i2;
  ham_term_t        ht;
  logic [31:0]      mul_a, mul_b;
  logic [ZR_W-1:0]  norm;
  logic [35:0]      sq_t, sq_trial;
  logic [32:0]      dv_t;
  logic [ZR_W-1:0]  mod_sub;
  logic signed [CW-1:0] z1, xs, ys, at;
  logic [47:0]      wround;
  logic [63:0]      qnum;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign i2 = cmd.idx[1:0];
  assign ht = ham_term(cmd.idx[3:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_WMUL: begin
        mul_a = {8'b0, rmag_r[i2]};
        mul_b = {8'b0, ts_r};
      end
      OP_SQMUL_W: begin
        mul_a = wm_r[i2][31:0];
        mul_b = wm_r[i2][31:0];
      end
      OP_SQMUL_M: begin
        mul_a = m_r[i2][31:0];
        mul_b = m_r[i2][31:0];
      end
      OP_RMUL: begin
        mul_a = sm_r;
        mul_b = wm_r[i2][31:0];
      end
      OP_HMUL: begin
        mul_a = mag32(q_r[ht.qa]);
        mul_b = mag32(r_r[ht.rb]);
      end
      default: begin
      end
    endcase
  end

  assign norm     = {7'b0, root_r} << sh_r;
  assign sq_t     = {rem_r, rad_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign dv_t     = {drem_r, dlo_r[31]};
  assign mod_sub  = {6'b0, ANG_TWO_PI} << cmd.idx[2:0];
  assign wround   = prod_r[47:0] + 48'd512;
  assign xs       = cx_r >>> cmd.idx;
  assign ys       = cy_r >>> cmd.idx;
  assign at       = $signed({4'b0, atan_q30(cmd.idx)});
  assign qnum     = ({33'b0, m_r[i2][30:0]} << QUAT_FRAC_BITS) + {33'b0, root_r[31:1]};

  always_comb begin
    z1 = $signed({1'b0, zred_r[32:0]});
    if (z1 > $signed({1'b0, ANG_PI})) begin
      z1 = z1 - $signed({1'b0, ANG_TWO_PI});
    end
  end

  assign stat.wbig = (wm_r[0][WM_W-1:31] != '0) || (wm_r[1][WM_W-1:31] != '0) ||
                     (wm_r[2][WM_W-1:31] != '0);
  assign stat.mbig = (m_r[0][MAG_W-1:31] != '0) || (m_r[1][MAG_W-1:31] != '0) ||
                     (m_r[2][MAG_W-1:31] != '0) || (m_r[3][MAG_W-1:31] != '0);
  assign stat.below_min = norm <= {23'b0, min_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= TS_RESET;
      min_r <= MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP: ts_r  <= cfg_data[TS_W-1:0];
        REG_MIN_ANGLE: min_r <= cfg_data[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r[0] <= QW'(64'd1 << QUAT_FRAC_BITS);
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else begin
      if (cmd.op == OP_ACCEPT && kind) begin
        for (int i = 0; i < 4; i++) q_r[i] <= load[i];
      end
      if (cmd.op == OP_QSTORE) begin
        if (root_r == '0) q_r[i2] <= '0;
        else q_r[i2] <= pneg_r[i2] ? (~dlo_r + 32'd1) : dlo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WMUL, OP_SQMUL_W, OP_SQMUL_M, OP_RMUL: prod_r <= mul_a * mul_b;
      OP_HMUL: begin
        prod_r <= mul_a * mul_b;
        hneg_r <= ht.neg ^ q_r[ht.qa][31] ^ r_r[ht.rb][31];
      end
      OP_ACCEPT: begin
        for (int i = 0; i < 3; i++) begin
          rneg_r[i] <= rate[i][RATE_W-1];
          rmag_r[i] <= rate[i][RATE_W-1] ? (~rate[i] + 24'd1) : rate[i];
        end
        sum_r <= '0;
        sh_r  <= '0;
      end
      OP_WROUND: wm_r[i2] <= wround[47:10];
      OP_WSHIFT: begin
        for (int i = 0; i < 3; i++) wm_r[i] <= wm_r[i] >> 1;
        sh_r <= sh_r + 3'd1;
      end
      OP_SUMACC: sum_r <= sum_r + prod_r;
      OP_SQRT_INI: begin
        rad_r  <= sum_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_SQRT_STP: begin
        rad_r <= {rad_r[61:0], 2'b00};
        if (sq_t >= sq_trial) begin
          rem_r  <= 34'(sq_t - sq_trial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= sq_t[33:0];
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      OP_HALF: zred_r <= {1'b0, norm[ZR_W-1:1]};
      OP_MOD: begin
        if (zred_r >= mod_sub) zred_r <= zred_r - mod_sub;
      end
      OP_FOLD: begin
        cx_r <= $signed({1'b0, CORDIC_GAIN});
        cy_r <= '0;
        if (z1 > $signed({1'b0, ANG_HALF_PI})) begin
          cz_r   <= $signed({1'b0, ANG_PI}) - z1;
          negc_r <= 1'b1;
        end else if (z1 < -$signed({1'b0, ANG_HALF_PI})) begin
          cz_r   <= -$signed({1'b0, ANG_PI}) - z1;
          negc_r <= 1'b1;
        end else begin
          cz_r   <= z1;
          negc_r <= 1'b0;
        end
      end
      OP_CORDIC: begin
        if (!cz_r[CW-1]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      OP_SINC: begin
        r_r[0] <= negc_r ? (~cx_r[31:0] + 32'd1) : cx_r[31:0];
        sm_r   <= cy_r[CW-1] ? 32'(-cy_r) : cy_r[31:0];
        sneg_r <= cy_r[CW-1];
        for (int i = 0; i < 4; i++) acc_r[i] <= '0;
      end
      OP_RDLOAD: begin
        drem_r <= prod_r[63:32];
        dlo_r  <= prod_r[31:0];
        dden_r <= root_r;
      end
      OP_QDLOAD: begin
        drem_r <= qnum[63:32];
        dlo_r  <= qnum[31:0];
        dden_r <= root_r;
      end
      OP_DIV_STP: begin
        if (dv_t >= {1'b0, dden_r}) begin
          drem_r <= 32'(dv_t - {1'b0, dden_r});
          dlo_r  <= {dlo_r[30:0], 1'b1};
        end else begin
          drem_r <= dv_t[31:0];
          dlo_r  <= {dlo_r[30:0], 1'b0};
        end
      end
      OP_RSTORE: begin
        r_r[2'(i2 + 2'd1)] <= (sneg_r ^ rneg_r[i2]) ? (~dlo_r + 32'd1) : dlo_r;
      end
      OP_HACC: begin
        if (hneg_r) acc_r[cmd.idx[3:2]] <= acc_r[cmd.idx[3:2]] - $signed({2'b00, prod_r});
        else acc_r[cmd.idx[3:2]] <= acc_r[cmd.idx[3:2]] + $signed({2'b00, prod_r});
      end
      OP_MMAG: begin
        for (int i = 0; i < 4; i++) begin
          pneg_r[i] <= acc_r[i][ACC_W-1];
          m_r[i]    <= acc_r[i][ACC_W-1] ? MAG_W'(-acc_r[i]) : acc_r[i][MAG_W-1:0];
        end
        sum_r <= '0;
      end
      OP_MSHIFT: begin
        for (int i = 0; i < 4; i++) m_r[i] <= m_r[i] >> 1;
      end
      OP_EMIT: begin
        for (int i = 0; i < 4; i++) out_q_r[i] <= q_r[i];
        out_unch_r <= cmd.flag;
      end
      default: begin
      end
    endcase
  end

  assign quat      = out_q_r;
  assign unchanged = out_unch_r;

endmodule

/* rtl/core/qgi_ctrl.sv */
// ----------------------------------------------------------------------------
// qgi_ctrl
// Sequencer of the integrator: issues datapath commands, owns the input and output handshakes.
// ----------------------------------------------------------------------------
module qgi_ctrl
  import qgi_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_kind,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_WMUL   = 5'd1;
  localparam logic [4:0] S_WRND   = 5'd2;
  localparam logic [4:0] S_WSHF   = 5'd3;
  localparam logic [4:0] S_SQMUL  = 5'd4;
  localparam logic [4:0] S_SQACC  = 5'd5;
  localparam logic [4:0] S_SQINIT = 5'd6;
  localparam logic [4:0] S_SQSTEP = 5'd7;
  localparam logic [4:0] S_CHECK  = 5'd8;
  localparam logic [4:0] S_MOD    = 5'd9;
  localparam logic [4:0] S_FOLD   = 5'd10;
  localparam logic [4:0] S_CORD   = 5'd11;
  localparam logic [4:0] S_SINC   = 5'd12;
  localparam logic [4:0] S_RMUL   = 5'd13;
  localparam logic [4:0] S_DLOAD  = 5'd14;
  localparam logic [4:0] S_DSTEP  = 5'd15;
  localparam logic [4:0] S_STORE  = 5'd16;
  localparam logic [4:0] S_HMUL   = 5'd17;
  localparam logic [4:0] S_HACC   = 5'd18;
  localparam logic [4:0] S_MMAG   = 5'd19;
  localparam logic [4:0] S_MSHF   = 5'd20;
  localparam logic [4:0] S_EMIT   = 5'd21;

  localparam logic [IDX_W-1:0] LAST_ITER = IDX_W'(CORDIC_ITERATIONS - 1);
  localparam logic [IDX_W-1:0] LAST_STEP = 5'd31;

  logic [4:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] jcnt_r, jcnt_nxt;
  logic             pass_r, pass_nxt;
  logic             flag_r, flag_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    jcnt_nxt      = jcnt_r;
    pass_nxt      = pass_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{op: OP_NONE, idx: cnt_r, flag: flag_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op   = OP_ACCEPT;
          cnt_nxt  = '0;
          pass_nxt = 1'b0;
          flag_nxt = 1'b0;
          state_nxt = in_kind ? S_EMIT : S_WMUL;
        end
      end
      S_WMUL: begin
        cmd.op    = OP_WMUL;
        state_nxt = S_WRND;
      end
      S_WRND: begin
        cmd.op = OP_WROUND;
        if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = S_WSHF;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_WMUL;
        end
      end
      S_WSHF: begin
        if (stat.wbig) cmd.op = OP_WSHIFT;
        else state_nxt = S_SQMUL;
      end
      S_SQMUL: begin
        cmd.op    = pass_r ? OP_SQMUL_M : OP_SQMUL_W;
        state_nxt = S_SQACC;
      end
      S_SQACC: begin
        cmd.op = OP_SUMACC;
        if (cnt_r == (pass_r ? 5'd3 : 5'd2)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQINIT;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_SQMUL;
        end
      end
      S_SQINIT: begin
        cmd.op    = OP_SQRT_INI;
        jcnt_nxt  = '0;
        state_nxt = S_SQSTEP;
      end
      S_SQSTEP: begin
        cmd.op = OP_SQRT_STP;
        if (jcnt_r == LAST_STEP) state_nxt = pass_r ? S_DLOAD : S_CHECK;
        else jcnt_nxt = jcnt_r + 5'd1;
      end
      S_CHECK: begin
        if (stat.below_min) begin
          flag_nxt  = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_HALF;
          cnt_nxt   = 5'd6;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (cnt_r == '0) state_nxt = S_FOLD;
        else cnt_nxt = cnt_r - 5'd1;
      end
      S_FOLD: begin
        cmd.op    = OP_FOLD;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.op = OP_CORDIC;
        if (cnt_r == LAST_ITER) begin
          cnt_nxt   = '0;
          state_nxt = S_SINC;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_SINC: begin
        cmd.op    = OP_SINC;
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        cmd.op    = OP_RMUL;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.op    = pass_r ? OP_QDLOAD : OP_RDLOAD;
        jcnt_nxt  = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DIV_STP;
        if (jcnt_r == LAST_STEP) state_nxt = S_STORE;
        else jcnt_nxt = jcnt_r + 5'd1;
      end
      S_STORE: begin
        cmd.op = pass_r ? OP_QSTORE : OP_RSTORE;
        if (!pass_r && cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = S_HMUL;
        end else if (pass_r && cnt_r == 5'd3) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = pass_r ? S_DLOAD : S_RMUL;
        end
      end
      S_HMUL: begin
        cmd.op    = OP_HMUL;
        state_nxt = S_HACC;
      end
      S_HACC: begin
        cmd.op = OP_HACC;
        if (cnt_r == 5'd15) begin
          cnt_nxt   = '0;
          state_nxt = S_MMAG;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_HMUL;
        end
      end
      S_MMAG: begin
        cmd.op    = OP_MMAG;
        state_nxt = S_MSHF;
      end
      S_MSHF: begin
        if (stat.mbig) begin
          cmd.op = OP_MSHIFT;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = S_SQMUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      jcnt_r      <= '0;
      pass_r      <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      jcnt_r      <= jcnt_nxt;
      pass_r      <= pass_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/quaternion_gyro_integrator.sv */
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator
// Attitude quaternion kept up to date from gyro words by the exponential map.
// ----------------------------------------------------------------------------
// Each input word yields one result word. A load word is written to the
// quaternion registers when taken, then copied to the output register. A
// gyro word at or below the angle threshold ends after the first square
// root. The normalizing shifts run one bit per cycle (at most 6 and 32).
// Time is set by the single shared multiplier, the 32-step square root run
// twice and the 32-step divider run seven times, one after another. A
// finished word waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
module quaternion_gyro_integrator
  import qgi_pkg::*;
#(
  parameter int QUAT_FRAC_BITS    = DEF_QUAT_FRAC_BITS,
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rate_x, rate_y, rate_z, load_w, load_x, load_y, load_z
  input  logic [199:0]          in_tdata,
  // kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [127:0]          out_tdata,
  // unchanged
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [RATE_W-1:0] rate [3];
  logic [QW-1:0]     load [4];
  logic [QW-1:0]     quat [4];

  assign rate[0] = in_tdata[23:0];
  assign rate[1] = in_tdata[47:24];
  assign rate[2] = in_tdata[71:48];
  assign load[0] = in_tdata[103:72];
  assign load[1] = in_tdata[135:104];
  assign load[2] = in_tdata[167:136];
  assign load[3] = in_tdata[199:168];

  assign cfg_ready = 1'b1;

  qgi_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qgi_datapath #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .kind     (in_tuser),
    .rate     (rate),
    .load     (load),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .quat     (quat),
    .unchanged(out_tuser)
  );

  assign out_tdata = {quat[3], quat[2], quat[1], quat[0]};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result word raised while idle");
`endif

endmodule
